FILE: hdl/pulse_width_sensor_frame_decoder_macros.svh
// Assertion macros for the decoder RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef PULSE_WIDTH_SENSOR_FRAME_DECODER_MACROS_SVH
`define PULSE_WIDTH_SENSOR_FRAME_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
// cons must hold in the same cycle as ante
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/pwsfd_pkg.sv
package pwsfd_pkg;

	localparam int PULSES_PER_FRAME = 42;
	localparam int DATA_BITS        = 40;
	localparam int INDEX_W          = 6;
	localparam int COUNT_W          = 8;
	localparam int REG_INDEX_W      = 3;

	// pulse numbers within a frame
	localparam logic [INDEX_W-1:0] RESPONSE_PULSE    = INDEX_W'(1);
	localparam logic [INDEX_W-1:0] FIRST_DATA_PULSE  = INDEX_W'(2);
	localparam logic [INDEX_W-1:0] FIRST_CHECK_PULSE = INDEX_W'(2 + DATA_BITS - COUNT_W);
	localparam logic [INDEX_W-1:0] LAST_PULSE        = INDEX_W'(PULSES_PER_FRAME - 1);
	// an early end after this pulse still leaves data-byte pulses to fill
	localparam logic [INDEX_W-1:0] LAST_DATA_FILL    = INDEX_W'(2 + DATA_BITS - COUNT_W - 2);
	localparam logic [INDEX_W-1:0] FULL_FILL         = INDEX_W'(DATA_BITS);

	// operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_PULSE = 1'b1;

	// register indexes
	localparam logic [REG_INDEX_W-1:0] REG_RESPONSE_MIN = REG_INDEX_W'(0);
	localparam logic [REG_INDEX_W-1:0] REG_RESPONSE_MAX = REG_INDEX_W'(1);
	localparam logic [REG_INDEX_W-1:0] REG_ONE_MIN      = REG_INDEX_W'(2);
	localparam logic [REG_INDEX_W-1:0] REG_ONE_MAX      = REG_INDEX_W'(3);
	localparam logic [REG_INDEX_W-1:0] REG_ZERO_MIN     = REG_INDEX_W'(4);
	localparam logic [REG_INDEX_W-1:0] REG_ZERO_MAX     = REG_INDEX_W'(5);
	localparam logic [REG_INDEX_W-1:0] REG_TIMEOUT      = REG_INDEX_W'(6);

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_CHECKSUM = 2'd1,
		STATUS_SYNC     = 2'd2,
		STATUS_SENSOR   = 2'd3
	} status_t;

	typedef struct packed {
		logic [COUNT_W-1:0] resp_lo;
		logic [COUNT_W-1:0] resp_hi;
		logic [COUNT_W-1:0] one_min;
		logic [COUNT_W-1:0] one_max;
		logic [COUNT_W-1:0] zero_min;
		logic [COUNT_W-1:0] zero_max;
		logic [COUNT_W-1:0] timeout;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		resp_lo:      COUNT_W'(145),
		resp_hi:      COUNT_W'(180),
		one_min:      COUNT_W'(100),
		one_max:      COUNT_W'(140),
		zero_min:     COUNT_W'(60),
		zero_max:     COUNT_W'(95),
		timeout:      COUNT_W'(200)
	};

	// window decisions for one interval, plus how a missing pulse decodes
	typedef struct packed {
		logic data_one;
		logic bad;
		logic response_hit;
		logic timeout_hit;
		logic fill_one;
		logic fill_bad;
		logic fill_response;
	} class_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] bits;
		logic                 response_ok;
		logic                 data_bad;
		logic                 check_bad;
	} frame_t;

	typedef struct packed {
		logic               active;
		logic [INDEX_W-1:0] index;
	} frame_state_t;

endpackage

FILE: hdl/pwsfd_classify.sv
module pwsfd_classify (
	input  pwsfd_pkg::cfg_t                    cfg,
	input  logic [pwsfd_pkg::COUNT_W-1:0]      interval,
	output pwsfd_pkg::class_t                  cls
);

	logic in_one;
	logic in_zero;

	assign in_one  = (interval >= cfg.one_min) && (interval <= cfg.one_max);
	assign in_zero = (interval >= cfg.zero_min) && (interval <= cfg.zero_max);

	always_comb begin
		cls.data_one     = in_one;
		cls.bad          = !in_one && !in_zero;
		cls.response_hit = (interval >= cfg.resp_lo) && (interval <= cfg.resp_hi);
		cls.timeout_hit  = interval >= cfg.timeout;
		// a missing pulse is a zero count, which sits in a window only if its low end is zero
		cls.fill_one      = cfg.one_min == '0;
		cls.fill_bad      = (cfg.one_min != '0) && (cfg.zero_min != '0);
		cls.fill_response = cfg.resp_lo == '0;
	end

endmodule

FILE: hdl/pwsfd_frame.sv
module pwsfd_frame (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  logic                    operation,
	input  pwsfd_pkg::class_t       cls,
	input  logic                    take,
	output logic                    ready,
	output logic                    snap_valid,
	output pwsfd_pkg::frame_t       snap,
	output pwsfd_pkg::frame_state_t state
);

	logic                                active_q;
	logic [pwsfd_pkg::INDEX_W-1:0]       index_q;
	pwsfd_pkg::frame_t                   frame_q;
	logic                                snap_valid_s2;
	pwsfd_pkg::frame_t                   snap_s2;

	logic                                is_data;
	logic                                is_check;
	logic                                last;
	logic [pwsfd_pkg::INDEX_W-1:0]       fill_n;
	logic [pwsfd_pkg::DATA_BITS-1:0]     bits_one;
	logic [pwsfd_pkg::DATA_BITS-1:0]     fill_mask;
	pwsfd_pkg::frame_t                   nxt;

	always_comb begin
		is_data  = index_q >= pwsfd_pkg::FIRST_DATA_PULSE;
		is_check = index_q >= pwsfd_pkg::FIRST_CHECK_PULSE;
		last     = cls.timeout_hit || (index_q == pwsfd_pkg::LAST_PULSE);

		// number of data pulses still missing after this one on an early end
		if (index_q == '0) begin
			fill_n = pwsfd_pkg::FULL_FILL;
		end else begin
			fill_n = pwsfd_pkg::LAST_PULSE - index_q;
		end

		bits_one  = is_data ? {frame_q.bits[pwsfd_pkg::DATA_BITS-2:0], cls.data_one}
		                    : frame_q.bits;
		fill_mask = ~({pwsfd_pkg::DATA_BITS{1'b1}} << fill_n);

		nxt = frame_q;
		if (cls.timeout_hit) begin
			nxt.bits = (bits_one << fill_n) | (cls.fill_one ? fill_mask : '0);
		end else begin
			nxt.bits = bits_one;
		end

		if (index_q == pwsfd_pkg::RESPONSE_PULSE) begin
			nxt.response_ok = cls.response_hit;
		end else if (index_q == '0 && cls.timeout_hit) begin
			nxt.response_ok = cls.fill_response;
		end

		nxt.data_bad = frame_q.data_bad
			| (is_data && !is_check && cls.bad)
			| (cls.timeout_hit && cls.fill_bad && index_q <= pwsfd_pkg::LAST_DATA_FILL);
		nxt.check_bad = frame_q.check_bad
			| (is_check && cls.bad)
			| (cls.timeout_hit && cls.fill_bad && fill_n != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			index_q  <= '0;
			frame_q  <= '0;
		end else if (fire) begin
			if (operation == pwsfd_pkg::OP_START) begin
				active_q <= 1'b1;
				index_q  <= '0;
				frame_q  <= '0;
			end else if (active_q) begin
				frame_q <= nxt;
				if (last) begin
					active_q <= 1'b0;
					index_q  <= '0;
				end else begin
					index_q <= index_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (fire && operation == pwsfd_pkg::OP_PULSE && active_q && last) begin
			snap_valid_s2 <= 1'b1;
		end else if (take) begin
			snap_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && active_q && last) begin
			snap_s2 <= nxt;
		end
	end

	assign ready        = !snap_valid_s2 || take;
	assign snap_valid   = snap_valid_s2;
	assign snap         = snap_s2;
	assign state.active = active_q;
	assign state.index  = index_q;

endmodule

FILE: hdl/pwsfd_result.sv
module pwsfd_result (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          snap_valid,
	input  pwsfd_pkg::frame_t             snap,
	output logic                          take,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [pwsfd_pkg::COUNT_W-1:0] humidity,
	output logic [pwsfd_pkg::COUNT_W-1:0] temperature
);

	logic [pwsfd_pkg::COUNT_W-1:0] b0, b1, b2, b3, b4;
	logic [pwsfd_pkg::COUNT_W-1:0] sum;
	pwsfd_pkg::status_t            st;
	logic                          open;

	logic                          out_valid_q;
	pwsfd_pkg::status_t            status_q;
	logic [pwsfd_pkg::COUNT_W-1:0] humidity_q;
	logic [pwsfd_pkg::COUNT_W-1:0] temperature_q;

	always_comb begin
		b0  = snap.bits[39:32];
		b1  = snap.bits[31:24];
		b2  = snap.bits[23:16];
		b3  = snap.bits[15:8];
		b4  = snap.bits[7:0];
		sum = b0 + b1 + b2 + b3;

		if (!snap.response_ok) begin
			st = pwsfd_pkg::STATUS_SENSOR;
		end else if (snap.data_bad) begin
			st = pwsfd_pkg::STATUS_SYNC;
		end else if (snap.check_bad || sum != b4) begin
			st = pwsfd_pkg::STATUS_CHECKSUM;
		end else begin
			st = pwsfd_pkg::STATUS_OK;
		end
	end

	assign open = !out_valid_q || out_ready;
	assign take = snap_valid && open;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (open) begin
			out_valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= st;
			if (st == pwsfd_pkg::STATUS_SYNC || st == pwsfd_pkg::STATUS_SENSOR) begin
				humidity_q    <= '0;
				temperature_q <= '0;
			end else begin
				humidity_q    <= b0;
				temperature_q <= b2;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign humidity    = humidity_q;
	assign temperature = temperature_q;

endmodule

FILE: hdl/pulse_width_sensor_frame_decoder.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    operation[0:0], interval[7:0]
// out      out_valid / out_ready  status[1:0], humidity[7:0], temperature[7:0]
// cfg      cfg_write              cfg_index[2:0], cfg_data[7:0]
//
// One item per cycle, sustained while out is not stalled: input register, frame update, result register.
// A frame's result passes from the input register through the frame snapshot into the result register on out.
// arst_n clears frame state and loads the default windows; no clearing pass.
// A stall on out backs up through the three registers; in_ready drops only
// when all of them hold an item.
`include "pulse_width_sensor_frame_decoder_macros.svh"

module pulse_width_sensor_frame_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [pwsfd_pkg::COUNT_W-1:0]     interval,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [pwsfd_pkg::COUNT_W-1:0]     humidity,
	output logic [pwsfd_pkg::COUNT_W-1:0]     temperature,
	input  logic                              cfg_write,
	input  logic [pwsfd_pkg::REG_INDEX_W-1:0] cfg_index,
	input  logic [pwsfd_pkg::COUNT_W-1:0]     cfg_data
);

	// window registers
	pwsfd_pkg::cfg_t cfg_q;

	// input register
	logic                          valid_s1;
	logic                          op_s1;
	logic [pwsfd_pkg::COUNT_W-1:0] interval_s1;
	logic                          s1_fire;

	// frame stage
	pwsfd_pkg::class_t       cls;
	logic                    s2_ready;
	logic                    snap_valid;
	pwsfd_pkg::frame_t       snap;
	pwsfd_pkg::frame_state_t frame_state;
	logic                    take;

	// check terms
	logic                    s1_start;
	logic                    frame_fresh;
	logic                    err_out;
	logic                    bytes_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pwsfd_pkg::CFG_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				pwsfd_pkg::REG_RESPONSE_MIN: cfg_q.resp_lo      <= cfg_data;
				pwsfd_pkg::REG_RESPONSE_MAX: cfg_q.resp_hi      <= cfg_data;
				pwsfd_pkg::REG_ONE_MIN:      cfg_q.one_min      <= cfg_data;
				pwsfd_pkg::REG_ONE_MAX:      cfg_q.one_max      <= cfg_data;
				pwsfd_pkg::REG_ZERO_MIN:     cfg_q.zero_min     <= cfg_data;
				pwsfd_pkg::REG_ZERO_MAX:     cfg_q.zero_max     <= cfg_data;
				pwsfd_pkg::REG_TIMEOUT:      cfg_q.timeout      <= cfg_data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	// input register moves whenever the frame stage can take its item
	assign s1_fire  = valid_s1 && s2_ready;
	assign in_ready = !valid_s1 || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1       <= operation;
			interval_s1 <= interval;
		end
	end

	pwsfd_classify u_classify (
		.cfg      (cfg_q),
		.interval (interval_s1),
		.cls      (cls)
	);

	// pulse counter, shift register and error flags; latches the finished frame
	pwsfd_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (s1_fire),
		.operation  (op_s1),
		.cls        (cls),
		.take       (take),
		.ready      (s2_ready),
		.snap_valid (snap_valid),
		.snap       (snap),
		.state      (frame_state)
	);

	// checksum, status priority and the result register
	pwsfd_result u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.snap_valid  (snap_valid),
		.snap        (snap),
		.take        (take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.humidity    (humidity),
		.temperature (temperature)
	);

	assign s1_start    = s1_fire && op_s1 == pwsfd_pkg::OP_START;
	assign frame_fresh = frame_state.active && frame_state.index == '0;
	assign err_out     = out_valid
		&& (status == pwsfd_pkg::STATUS_SYNC || status == pwsfd_pkg::STATUS_SENSOR);
	assign bytes_zero  = humidity == '0 && temperature == '0;

	`ASSERT_HOLDS(a_stall_full, clk, arst_n, !in_ready, valid_s1 && snap_valid, "in stalled")
	`ASSERT_NEXT(a_start_opens, clk, arst_n, s1_start, frame_fresh, "start did not open frame")
	`ASSERT_HOLDS(a_end_closes, clk, arst_n, $rose(snap_valid), !frame_state.active, "frame open")
	`ASSERT_HOLDS(a_err_zero, clk, arst_n, err_out, bytes_zero, "error result carries data")

endmodule
